// ===== sv/fkic_pkg.sv =====
package fkic_pkg;

   localparam int DEPTH_DEFAULT    = 16;
   localparam int KEY_BITS_DEFAULT = 64;

   localparam int FIELD_W     = 64;
   localparam int CAP_W       = 5;
   localparam int COUNT_OUT_W = 5;
   localparam int TOTAL_W     = 32;

   localparam logic [CAP_W-1:0]   CAPACITY_RESET = 5'd16;
   localparam logic [FIELD_W-1:0] SERIAL_RESET   = 64'd1;

   typedef enum logic [1:0] {
      OP_ACQUIRE = 2'd0,
      OP_QUERY   = 2'd1,
      OP_CLEAR   = 2'd2,
      OP_NOP     = 2'd3
   } op_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic take_hit;
      logic insert;
      logic clear;
   } ctrl_cmd_type;

   typedef struct packed {
      logic match;
      logic scan_done;
      logic is_acquire;
   } dp_status_type;

endpackage

// ===== sv/fifo_key_to_id_cache_unit.sv =====
// Key-to-id cache with FIFO replacement. A transaction is accepted when start is high
// and busy is low; busy then stays high until its result has been presented, so one
// transaction is in flight at a time. The result appears for exactly one cycle with
// rsp_valid high and cannot be stalled: sample it in that cycle. Lookups walk the held
// entries oldest first, one entry per clock through the key and id memories (one read
// port each). An acquire or query loads the request and scans until the first match or
// until every held entry has been read; an acquire that misses then writes the new entry
// in the insert state before the response state. A clear or no-op goes from idle
// straight to the response state. busy falls as the result is taken, so the next
// transaction can be accepted at the following edge. Capacity may be written at any time
// the block is idle; it takes effect from the next transaction.
module fifo_key_to_id_cache_unit #(
   parameter int DEPTH    = fkic_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = fkic_pkg::KEY_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_op,
   input  logic [fkic_pkg::FIELD_W-1:0]        req_key,
   input  logic [fkic_pkg::FIELD_W-1:0]        req_id,
   input  logic                                csr_wr_en,
   input  logic [fkic_pkg::CAP_W-1:0]          csr_wr_data,
   output logic                                rsp_valid,
   output logic                                rsp_hit,
   output logic                                rsp_created,
   output logic [fkic_pkg::FIELD_W-1:0]        rsp_id_out,
   output logic [fkic_pkg::FIELD_W-1:0]        rsp_key_out,
   output logic [fkic_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic [fkic_pkg::TOTAL_W-1:0]        rsp_created_total,
   output logic [fkic_pkg::TOTAL_W-1:0]        rsp_reused_total,
   output logic [fkic_pkg::TOTAL_W-1:0]        rsp_evicted_total
);

   fkic_pkg::ctrl_cmd_type  cmd;
   fkic_pkg::dp_status_type status;
   fkic_pkg::op_type        op;

   assign op = fkic_pkg::op_type'(req_op);

   fkic_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_op    (op),
      .status    (status),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   fkic_dp #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_op            (op),
      .req_key           (req_key),
      .req_id            (req_id),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_hit           (rsp_hit),
      .rsp_created       (rsp_created),
      .rsp_id_out        (rsp_id_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_created_total (rsp_created_total),
      .rsp_reused_total  (rsp_reused_total),
      .rsp_evicted_total (rsp_evicted_total)
   );

endmodule

// ===== sv/fkic_ram.sv =====
module fkic_ram #(
   parameter int WIDTH = fkic_pkg::FIELD_W,
   parameter int DEPTH = fkic_pkg::DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                     wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fkic_ctrl.sv =====
module fkic_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  fkic_pkg::op_type       req_op,
   input  fkic_pkg::dp_status_type status,
   output fkic_pkg::ctrl_cmd_type cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_INSERT = 4'b0100,
      ST_RESP   = 4'b1000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_op inside {fkic_pkg::OP_ACQUIRE, fkic_pkg::OP_QUERY}) begin
                  state_in = ST_SCAN;
               end else begin
                  cmd.clear = (req_op == fkic_pkg::OP_CLEAR);
                  state_in  = ST_RESP;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.match) begin
               cmd.take_hit = 1'b1;
               state_in     = ST_RESP;
            end else if (status.scan_done) begin
               state_in = status.is_acquire ? ST_INSERT : ST_RESP;
            end
         end
         ST_INSERT: begin
            cmd.insert = 1'b1;
            state_in   = ST_RESP;
         end
         ST_RESP: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

// ===== sv/fkic_dp.sv =====
module fkic_dp #(
   parameter int DEPTH    = fkic_pkg::DEPTH_DEFAULT,
   parameter int KEY_BITS = fkic_pkg::KEY_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  fkic_pkg::ctrl_cmd_type              cmd,
   output fkic_pkg::dp_status_type             status,
   input  fkic_pkg::op_type                    req_op,
   input  logic [fkic_pkg::FIELD_W-1:0]        req_key,
   input  logic [fkic_pkg::FIELD_W-1:0]        req_id,
   input  logic                                csr_wr_en,
   input  logic [fkic_pkg::CAP_W-1:0]          csr_wr_data,
   output logic                                rsp_hit,
   output logic                                rsp_created,
   output logic [fkic_pkg::FIELD_W-1:0]        rsp_id_out,
   output logic [fkic_pkg::FIELD_W-1:0]        rsp_key_out,
   output logic [fkic_pkg::COUNT_OUT_W-1:0]    rsp_entry_count,
   output logic [fkic_pkg::TOTAL_W-1:0]        rsp_created_total,
   output logic [fkic_pkg::TOTAL_W-1:0]        rsp_reused_total,
   output logic [fkic_pkg::TOTAL_W-1:0]        rsp_evicted_total
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int EW    = (CNT_W > fkic_pkg::COUNT_OUT_W) ? CNT_W : fkic_pkg::COUNT_OUT_W;
   localparam int SW    = CNT_W + 1;
   localparam int FW    = fkic_pkg::FIELD_W;
   localparam int TW    = fkic_pkg::TOTAL_W;

   fkic_pkg::op_type          op_ff;
   logic [KEY_BITS-1:0]       key_ff;
   logic [FW-1:0]             id_ff;
   logic [IDX_W-1:0]          oldest_ff;
   logic [CNT_W-1:0]          held_ff;
   logic [FW-1:0]             serial_ff;
   logic [TW-1:0]             created_ctr_ff;
   logic [TW-1:0]             reused_ctr_ff;
   logic [TW-1:0]             evicted_ctr_ff;
   logic [fkic_pkg::CAP_W-1:0] capacity_ff;
   logic [CNT_W-1:0]          scan_cnt_ff;
   logic [IDX_W-1:0]          scan_addr_ff;
   logic                      rd_pend_ff;
   logic                      hit_ff;
   logic                      created_ff;
   logic [FW-1:0]             id_out_ff;
   logic [FW-1:0]             key_out_ff;

   logic [KEY_BITS-1:0]       key_rd;
   logic [FW-1:0]             id_rd;
   logic                      scan_more;
   logic                      is_acquire;
   logic [EW-1:0]             cap_ext;
   logic [EW-1:0]             eff_cap;
   logic [EW-1:0]             held_ext;
   logic                      evict;
   logic [IDX_W-1:0]          oldest_n;
   logic [CNT_W-1:0]          cnt_e;
   logic [SW-1:0]             slot_sum;
   logic [SW-1:0]             slot_wrap;
   logic [IDX_W-1:0]          wr_slot;

   function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] a);
      idx_inc = (a == IDX_W'(DEPTH - 1)) ? '0 : a + IDX_W'(1);
   endfunction

   function automatic logic [TW-1:0] sat_inc(input logic [TW-1:0] v);
      sat_inc = (&v) ? v : v + TW'(1);
   endfunction

   fkic_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (wr_slot),
      .wr_data (key_ff),
      .rd_addr (scan_addr_ff),
      .rd_data (key_rd)
   );

   fkic_ram #(.WIDTH(FW), .DEPTH(DEPTH)) u_id_ram (
      .clock   (clock),
      .wr_en   (cmd.insert),
      .wr_addr (wr_slot),
      .wr_data (serial_ff),
      .rd_addr (scan_addr_ff),
      .rd_data (id_rd)
   );

   assign is_acquire = (op_ff == fkic_pkg::OP_ACQUIRE);
   assign scan_more  = (scan_cnt_ff != held_ff);

   assign status.is_acquire = is_acquire;
   assign status.match      = rd_pend_ff && (is_acquire ? (key_rd == key_ff) : (id_rd == id_ff));
   assign status.scan_done  = !rd_pend_ff && !scan_more;

   // clamp capacity to 1..DEPTH
   always_comb begin
      cap_ext  = EW'(capacity_ff);
      held_ext = EW'(held_ff);
      if (cap_ext == '0) begin
         eff_cap = EW'(1);
      end else if (cap_ext > EW'(DEPTH)) begin
         eff_cap = EW'(DEPTH);
      end else begin
         eff_cap = cap_ext;
      end
   end

   assign evict    = (held_ext >= eff_cap);
   assign oldest_n = evict ? idx_inc(oldest_ff) : oldest_ff;
   assign cnt_e    = evict ? held_ff - CNT_W'(1) : held_ff;
   assign slot_sum = SW'(oldest_n) + SW'(cnt_e);
   assign slot_wrap = (slot_sum >= SW'(DEPTH)) ? slot_sum - SW'(DEPTH) : slot_sum;
   assign wr_slot  = slot_wrap[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         oldest_ff      <= '0;
         held_ff        <= '0;
         serial_ff      <= fkic_pkg::SERIAL_RESET;
         created_ctr_ff <= '0;
         reused_ctr_ff  <= '0;
         evicted_ctr_ff <= '0;
         capacity_ff    <= fkic_pkg::CAPACITY_RESET;
         rd_pend_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (cmd.clear) begin
            oldest_ff <= '0;
            held_ff   <= '0;
         end
         rd_pend_ff <= cmd.scan && scan_more;
         if (cmd.take_hit) begin
            if (is_acquire) begin
               reused_ctr_ff <= sat_inc(reused_ctr_ff);
            end
         end
         if (cmd.insert) begin
            if (evict) begin
               evicted_ctr_ff <= sat_inc(evicted_ctr_ff);
            end
            oldest_ff      <= oldest_n;
            held_ff        <= cnt_e + CNT_W'(1);
            serial_ff      <= serial_ff + FW'(1);
            created_ctr_ff <= sat_inc(created_ctr_ff);
         end
      end
   end

   // transaction payload and scan pointer
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff        <= req_op;
         key_ff       <= req_key[KEY_BITS-1:0];
         id_ff        <= req_id;
         scan_cnt_ff  <= '0;
         scan_addr_ff <= oldest_ff;
         hit_ff       <= 1'b0;
         created_ff   <= 1'b0;
         id_out_ff    <= '0;
         key_out_ff   <= '0;
      end else begin
         if (cmd.scan && scan_more) begin
            scan_cnt_ff  <= scan_cnt_ff + CNT_W'(1);
            scan_addr_ff <= idx_inc(scan_addr_ff);
         end
         if (cmd.take_hit) begin
            hit_ff <= 1'b1;
            if (is_acquire) begin
               id_out_ff <= id_rd;
            end else begin
               key_out_ff <= FW'(key_rd);
            end
         end
         if (cmd.insert) begin
            created_ff <= 1'b1;
            id_out_ff  <= serial_ff;
         end
      end
   end

   assign rsp_hit           = hit_ff;
   assign rsp_created       = created_ff;
   assign rsp_id_out        = id_out_ff;
   assign rsp_key_out       = key_out_ff;
   assign rsp_entry_count   = held_ext[fkic_pkg::COUNT_OUT_W-1:0];
   assign rsp_created_total = created_ctr_ff;
   assign rsp_reused_total  = reused_ctr_ff;
   assign rsp_evicted_total = evicted_ctr_ff;

endmodule

// ===== tb/fifo_key_to_id_cache_unit_test.sv =====
module fifo_key_to_id_cache_unit_test;

   localparam int FIELD_W     = fkic_pkg::FIELD_W;
   localparam int CAP_W       = fkic_pkg::CAP_W;
   localparam int COUNT_OUT_W = fkic_pkg::COUNT_OUT_W;
   localparam int TOTAL_W     = fkic_pkg::TOTAL_W;
   localparam int SLOTS       = fkic_pkg::DEPTH_DEFAULT;
   localparam int POOL_SIZE   = 24;
   localparam int PHASES      = 8;
   localparam int PHASE_OPS   = 160;
   localparam int DUE_SLOTS   = 8;

   typedef enum logic {
      ROW_CMD,
      ROW_CAP
   } row_kind_type;

   typedef struct packed {
      logic                   hit;
      logic                   created;
      logic [FIELD_W-1:0]     id_out;
      logic [FIELD_W-1:0]     key_out;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic [TOTAL_W-1:0]     created_total;
      logic [TOTAL_W-1:0]     reused_total;
      logic [TOTAL_W-1:0]     evicted_total;
   } cache_rsp_type;

   typedef struct packed {
      row_kind_type       kind;
      fkic_pkg::op_type   op;
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] id;
      logic [CAP_W-1:0]   cap;
      logic               typed;
      cache_rsp_type      want;
   } stim_row_type;

   localparam cache_rsp_type      NO_RSP    = '0;
   localparam logic [FIELD_W-1:0] KEY_ZERO  = 64'h0000_0000_0000_0000;
   localparam logic [FIELD_W-1:0] KEY_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [FIELD_W-1:0] KEY_ALT_A = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [FIELD_W-1:0] KEY_ALT_5 = 64'h5555_5555_5555_5555;
   localparam logic [FIELD_W-1:0] KEY_MIX   = 64'h0123_4567_89AB_CDEF;
   localparam int DIR_ROWS = 25;

   // kind, op, key, id, capacity, typed, then the typed result:
   // hit, created, id_out, key_out, entry_count, created/reused/evicted totals
   stim_row_type dir_table [DIR_ROWS] = '{
      {ROW_CMD, fkic_pkg::OP_QUERY,   KEY_ZERO,  64'd0,    5'd0, 1'b1,
       {1'b0, 1'b0, 64'd0, KEY_ZERO, 5'd0, 32'd0, 32'd0, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_NOP,     KEY_ONES,  KEY_ONES, 5'd0, 1'b1,
       {1'b0, 1'b0, 64'd0, KEY_ZERO, 5'd0, 32'd0, 32'd0, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ZERO,  64'd0,    5'd0, 1'b1,
       {1'b0, 1'b1, 64'd1, KEY_ZERO, 5'd1, 32'd1, 32'd0, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ONES,  KEY_ONES, 5'd0, 1'b1,
       {1'b0, 1'b1, 64'd2, KEY_ZERO, 5'd2, 32'd2, 32'd0, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ZERO,  64'd0,    5'd0, 1'b1,
       {1'b1, 1'b0, 64'd1, KEY_ZERO, 5'd2, 32'd2, 32'd1, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_QUERY,   KEY_ZERO,  64'd2,    5'd0, 1'b1,
       {1'b1, 1'b0, 64'd0, KEY_ONES, 5'd2, 32'd2, 32'd1, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_QUERY,   KEY_ONES,  KEY_ONES, 5'd0, 1'b1,
       {1'b0, 1'b0, 64'd0, KEY_ZERO, 5'd2, 32'd2, 32'd1, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_CLEAR,   KEY_ALT_A, KEY_ALT_5, 5'd0, 1'b1,
       {1'b0, 1'b0, 64'd0, KEY_ZERO, 5'd0, 32'd2, 32'd1, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_QUERY,   KEY_ZERO,  64'd1,    5'd0, 1'b1,
       {1'b0, 1'b0, 64'd0, KEY_ZERO, 5'd0, 32'd2, 32'd1, 32'd0}},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ALT_A, 64'd0,    5'd0, 1'b1,
       {1'b0, 1'b1, 64'd3, KEY_ZERO, 5'd1, 32'd3, 32'd1, 32'd0}},
      {ROW_CAP, fkic_pkg::OP_NOP,     KEY_ZERO,  64'd0,    5'd0, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ALT_5, 64'd0,    5'd0, 1'b1,
       {1'b0, 1'b1, 64'd4, KEY_ZERO, 5'd1, 32'd4, 32'd1, 32'd1}},
      {ROW_CMD, fkic_pkg::OP_QUERY,   KEY_ZERO,  64'd3,    5'd0, 1'b1,
       {1'b0, 1'b0, 64'd0, KEY_ZERO, 5'd1, 32'd4, 32'd1, 32'd1}},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ALT_5, 64'd0,    5'd0, 1'b1,
       {1'b1, 1'b0, 64'd4, KEY_ZERO, 5'd1, 32'd4, 32'd2, 32'd1}},
      {ROW_CAP, fkic_pkg::OP_NOP,     KEY_ZERO,  64'd0,    5'd16, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ALT_A, 64'd0,    5'd0, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ONES,  64'd0,    5'd0, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ZERO,  64'd0,    5'd0, 1'b0, NO_RSP},
      {ROW_CAP, fkic_pkg::OP_NOP,     KEY_ZERO,  64'd0,    5'd2, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_MIX,   64'd0,    5'd0, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ALT_5, 64'd0,    5'd0, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_QUERY,   KEY_ZERO,  64'd6,    5'd0, 1'b0, NO_RSP},
      {ROW_CAP, fkic_pkg::OP_NOP,     KEY_ZERO,  64'd0,    5'd31, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_ACQUIRE, KEY_ONES,  64'd0,    5'd0, 1'b0, NO_RSP},
      {ROW_CMD, fkic_pkg::OP_NOP,     KEY_MIX,   KEY_MIX,  5'd0, 1'b0, NO_RSP}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic [1:0]               req_op = fkic_pkg::OP_NOP;
   logic [FIELD_W-1:0]       req_key = '0;
   logic [FIELD_W-1:0]       req_id = '0;
   logic                     csr_wr_en = 1'b0;
   logic [CAP_W-1:0]         csr_wr_data = '0;
   logic                     busy;
   logic                     rsp_valid;
   logic                     rsp_hit;
   logic                     rsp_created;
   logic [FIELD_W-1:0]       rsp_id_out;
   logic [FIELD_W-1:0]       rsp_key_out;
   logic [COUNT_OUT_W-1:0]   rsp_entry_count;
   logic [TOTAL_W-1:0]       rsp_created_total;
   logic [TOTAL_W-1:0]       rsp_reused_total;
   logic [TOTAL_W-1:0]       rsp_evicted_total;

   // Own copy of the table contents
   logic [FIELD_W-1:0] slot_key [SLOTS];
   logic [FIELD_W-1:0] slot_id [SLOTS];
   bit                 slot_live [SLOTS];
   int                 head_slot;
   int                 live_count;
   logic [FIELD_W-1:0] serial_next;
   logic [TOTAL_W-1:0] tot_created;
   logic [TOTAL_W-1:0] tot_reused;
   logic [TOTAL_W-1:0] tot_evicted;
   logic [CAP_W-1:0]   cap_setting;

   // expected results in order, written at acceptance and read at the strobe
   cache_rsp_type      rsp_due [DUE_SLOTS];
   int                 due_wr = 0;
   int                 due_rd = 0;
   int                 mismatch_count = 0;
   logic [FIELD_W-1:0] key_pool [POOL_SIZE];

   fifo_key_to_id_cache_unit dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_key           (req_key),
      .req_id            (req_id),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_created       (rsp_created),
      .rsp_id_out        (rsp_id_out),
      .rsp_key_out       (rsp_key_out),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_created_total (rsp_created_total),
      .rsp_reused_total  (rsp_reused_total),
      .rsp_evicted_total (rsp_evicted_total)
   );

   always #10 clock = ~clock;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

   function automatic logic [FIELD_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Apply one transaction to the table copy and return the result it produces.
   function automatic cache_rsp_type apply_cache_op(input fkic_pkg::op_type op,
                                                    input logic [FIELD_W-1:0] key,
                                                    input logic [FIELD_W-1:0] id);
      cache_rsp_type r;
      bit            found;
      int            i;
      int            s;
      int            eff;
      r = '0;
      found = 1'b0;
      eff = int'(cap_setting);
      if (eff < 1) eff = 1;
      if (eff > SLOTS) eff = SLOTS;
      case (op)
         fkic_pkg::OP_ACQUIRE: begin
            for (i = 0; i < live_count; i++) begin
               s = (head_slot + i) % SLOTS;
               if (!found && slot_live[s] && slot_key[s] == key) begin
                  found = 1'b1;
                  r.id_out = slot_id[s];
               end
            end
            if (found) begin
               r.hit = 1'b1;
               tot_reused = sat_inc(tot_reused);
            end else begin
               // drop exactly one oldest entry, even if the count is above capacity
               if (live_count >= eff) begin
                  slot_live[head_slot] = 1'b0;
                  head_slot = (head_slot + 1) % SLOTS;
                  live_count--;
                  tot_evicted = sat_inc(tot_evicted);
               end
               s = (head_slot + live_count) % SLOTS;
               slot_key[s] = key;
               slot_id[s] = serial_next;
               slot_live[s] = 1'b1;
               live_count++;
               r.id_out = serial_next;
               r.created = 1'b1;
               serial_next = serial_next + 1'b1;
               tot_created = sat_inc(tot_created);
            end
         end
         fkic_pkg::OP_QUERY: begin
            // oldest first, so a duplicated id returns the older entry
            for (i = 0; i < live_count; i++) begin
               s = (head_slot + i) % SLOTS;
               if (!found && slot_live[s] && slot_id[s] == id) begin
                  found = 1'b1;
                  r.hit = 1'b1;
                  r.key_out = slot_key[s];
               end
            end
         end
         fkic_pkg::OP_CLEAR: begin
            for (i = 0; i < SLOTS; i++) slot_live[i] = 1'b0;
            head_slot = 0;
            live_count = 0;
         end
         default: begin
         end
      endcase
      r.entry_count = COUNT_OUT_W'(live_count);
      r.created_total = tot_created;
      r.reused_total = tot_reused;
      r.evicted_total = tot_evicted;
      return r;
   endfunction

   // Hold the transaction until it is taken, then record what it should return.
   task automatic issue(input fkic_pkg::op_type op, input logic [FIELD_W-1:0] key,
                        input logic [FIELD_W-1:0] id, input logic typed,
                        input cache_rsp_type typed_rsp);
      cache_rsp_type predicted;
      req_op <= op;
      req_key <= key;
      req_id <= id;
      start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = apply_cache_op(op, key, id);
      rsp_due[due_wr % DUE_SLOTS] = typed ? typed_rsp : predicted;
      due_wr++;
   endtask

   task automatic idle_burst(input int pct);
      if ($urandom_range(0, 99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] value);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      cap_setting = value;
   endtask

   always @(posedge clock) begin : rsp_check
      cache_rsp_type got;
      cache_rsp_type want;
      if (!reset && rsp_valid) begin
         got = {rsp_hit, rsp_created, rsp_id_out, rsp_key_out, rsp_entry_count,
                rsp_created_total, rsp_reused_total, rsp_evicted_total};
         if (due_wr == due_rd) begin
            if (mismatch_count < 10)
               $display("unexpected transaction result: hit=%0d created=%0d id=%h key=%h",
                        got.hit, got.created, got.id_out, got.key_out);
            mismatch_count++;
         end else begin
            want = rsp_due[due_rd % DUE_SLOTS];
            due_rd++;
            if (got !== want) begin
               if (mismatch_count < 10) begin
                  $display({"mismatch expected: hit=%0d created=%0d id=%h key=%h",
                            " cnt=%0d tot=%0d/%0d/%0d"},
                           want.hit, want.created, want.id_out, want.key_out,
                           want.entry_count, want.created_total, want.reused_total,
                           want.evicted_total);
                  $display({"         actual:   hit=%0d created=%0d id=%h key=%h",
                            " cnt=%0d tot=%0d/%0d/%0d"},
                           got.hit, got.created, got.id_out, got.key_out,
                           got.entry_count, got.created_total, got.reused_total,
                           got.evicted_total);
               end
               mismatch_count++;
            end
         end
      end
   end

   initial begin : stimulus
      logic [CAP_W-1:0]   cap_plan [PHASES];
      logic [FIELD_W-1:0] key;
      logic [FIELD_W-1:0] id;
      fkic_pkg::op_type   op;
      int                 sel;
      int                 idle_pct;
      int                 pool_span;
      int                 ph;
      int                 n;

      for (n = 0; n < SLOTS; n++) begin
         slot_key[n] = '0;
         slot_id[n] = '0;
         slot_live[n] = 1'b0;
      end
      head_slot = 0;
      live_count = 0;
      serial_next = fkic_pkg::SERIAL_RESET;
      tot_created = '0;
      tot_reused = '0;
      tot_evicted = '0;
      cap_setting = fkic_pkg::CAPACITY_RESET;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[r]) begin
         if (dir_table[r].kind == ROW_CAP) begin
            write_capacity(dir_table[r].cap);
         end else begin
            issue(dir_table[r].op, dir_table[r].key, dir_table[r].id,
                  dir_table[r].typed, dir_table[r].want);
            idle_burst(30);
         end
      end

      cap_plan = '{5'd31, 5'd1, 5'd0, 5'd16, 5'd5, 5'd17,
                   CAP_W'($urandom_range(2, 15)), CAP_W'($urandom_range(0, 31))};
      for (ph = 0; ph < PHASES; ph++) begin
         write_capacity(cap_plan[ph]);
         // no idling in the final phase
         case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 20;
            default: idle_pct = 50;
         endcase
         if (ph == PHASES - 1) idle_pct = 0;
         pool_span = $urandom_range(4, POOL_SIZE);
         foreach (key_pool[k]) key_pool[k] = rand64();
         repeat (PHASE_OPS) begin
            sel = $urandom_range(0, 99);
            key = rand64();
            id = rand64();
            if (sel < 62) begin
               op = fkic_pkg::OP_ACQUIRE;
               if ($urandom_range(0, 9) != 0) key = key_pool[$urandom_range(0, pool_span - 1)];
            end else if (sel < 93) begin
               op = fkic_pkg::OP_QUERY;
               // aim most queries at recently assigned ids
               if ($urandom_range(0, 4) != 0) id = serial_next - $urandom_range(1, 24);
               else if ($urandom_range(0, 3) == 0) id = '0;
            end else if (sel < 98) begin
               op = fkic_pkg::OP_NOP;
            end else begin
               op = fkic_pkg::OP_CLEAR;
            end
            issue(op, key, id, 1'b0, NO_RSP);
            idle_burst(idle_pct);
         end
      end

      start <= 1'b0;
      while (due_wr != due_rd) @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatch_count == 0 && due_wr == due_rd)
         $display("fifo_key_to_id_cache_unit test passed");
      else
         $display("fifo_key_to_id_cache_unit test failed");
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("fifo_key_to_id_cache_unit test failed");
      $finish;
   end

endmodule
